FILE: rtl/pam_pkg.sv
`timescale 1ns / 1ps

package pam_pkg;

    localparam int AVG_LEN_DEF   = 10;
    localparam int PWM_STEPS_DEF = 100;

    localparam int ADC_W  = 10;
    localparam int SUM_W  = 14;
    localparam int CNT_W  = 4;
    localparam int PWM_W  = 7;
    localparam int CMP_W  = CNT_W + 1;

    // item kinds carried on tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = QPTR_W + 1;

    // block average: sum * ceil(2^19 / AVG_LEN) >> 19, exact for 14-bit sums
    localparam int AVG_SHIFT = SUM_W + 5;

    // reciprocal constants, ceil(N * 2^S / D); exact over the operand ranges used
    localparam int SPEED_SHIFT = 17;
    localparam int SPEED_MUL_W = 15;
    localparam logic [SPEED_MUL_W-1:0] SPEED_MUL =
        SPEED_MUL_W'((20 * (2 ** SPEED_SHIFT) + 102) / 103);

    localparam int ANGLE_SHIFT = 20;
    localparam int ANGLE_MUL_W = 18;
    localparam logic [ANGLE_MUL_W-1:0] ANGLE_MUL =
        ANGLE_MUL_W'((100 * (2 ** ANGLE_SHIFT) + 566) / 567);

    localparam int SERVO_SHIFT = 11;
    localparam int SERVO_MUL_W = 15;
    localparam logic [SERVO_MUL_W-1:0] SERVO_MUL =
        SERVO_MUL_W'((124 * (2 ** SERVO_SHIFT) + 9) / 10);

    localparam logic [8:0]  SPEED_OFFSET = 9'd99;
    localparam logic [8:0]  ANGLE_OFFSET = 9'd90;
    localparam logic [10:0] MOTOR_GAIN   = 11'(1999 / 99);
    localparam logic [11:0] SERVO_BASE   = 12'((8749 / 70) * 6);

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum_speed;
        logic [SUM_W-1:0] sum_angle;
        logic [PWM_W-1:0] pwm_cmp;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

FILE: rtl/pam_front.sv
`timescale 1ns / 1ps

module pam_front #(
    parameter int AVG_LEN   = pam_pkg::AVG_LEN_DEF,
    parameter int PWM_STEPS = pam_pkg::PWM_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [23:0]         s_axis_tdata,
    input  logic [0:0]          s_axis_tuser,
    input  pam_pkg::q_status_t  q_status,
    output logic                q_push,
    output pam_pkg::qentry_t    q_wdata
);

    logic [pam_pkg::SUM_W-1:0] sum_speed_reg, sum_speed_next, sum_speed_add;
    logic [pam_pkg::SUM_W-1:0] sum_angle_reg, sum_angle_next, sum_angle_add;
    logic [pam_pkg::CNT_W-1:0] cnt_reg, cnt_next, cnt_add;
    logic [pam_pkg::PWM_W-1:0] pwm_reg, pwm_next, pwm_inc;
    logic [pam_pkg::ADC_W-1:0] chan0, chan1;
    logic                      is_tick, block_done, pwm_wrap;

    assign chan0   = s_axis_tdata[pam_pkg::ADC_W-1:0];
    assign chan1   = s_axis_tdata[2*pam_pkg::ADC_W-1:pam_pkg::ADC_W];
    assign is_tick = (s_axis_tuser[0] == pam_pkg::FUNC_TICK);

    assign s_axis_tready = ~q_status.full;
    assign q_push        = s_axis_tvalid & s_axis_tready;

    assign sum_speed_add = sum_speed_reg + pam_pkg::SUM_W'(chan0);
    assign sum_angle_add = sum_angle_reg + pam_pkg::SUM_W'(chan1);
    assign cnt_add       = cnt_reg + 1'b1;
    // a full-length count of 16 wraps to zero and also closes the block
    assign block_done    = ({1'b0, cnt_add} >= pam_pkg::CMP_W'(AVG_LEN)) || (cnt_add == '0);

    assign pwm_inc  = pwm_reg + 1'b1;
    assign pwm_wrap = (pwm_inc >= pam_pkg::PWM_W'(PWM_STEPS));

    always_comb
    begin
        q_wdata.done      = ~is_tick & block_done;
        q_wdata.sum_speed = sum_speed_add;
        q_wdata.sum_angle = sum_angle_add;
        q_wdata.pwm_cmp   = is_tick ? pwm_inc : pwm_reg;
    end

    always_comb
    begin
        sum_speed_next = sum_speed_reg;
        sum_angle_next = sum_angle_reg;
        cnt_next       = cnt_reg;
        pwm_next       = pwm_reg;
        if (q_push)
        begin
            if (is_tick)
            begin
                pwm_next = pwm_wrap ? '0 : pwm_inc;
            end
            else if (block_done)
            begin
                sum_speed_next = '0;
                sum_angle_next = '0;
                cnt_next       = '0;
            end
            else
            begin
                sum_speed_next = sum_speed_add;
                sum_angle_next = sum_angle_add;
                cnt_next       = cnt_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_speed_reg <= '0;
            sum_angle_reg <= '0;
            cnt_reg       <= '0;
            pwm_reg       <= '0;
        end
        else
        begin
            sum_speed_reg <= sum_speed_next;
            sum_angle_reg <= sum_angle_next;
            cnt_reg       <= cnt_next;
            pwm_reg       <= pwm_next;
        end
    end

endmodule

FILE: rtl/pam_fifo.sv
`timescale 1ns / 1ps

module pam_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pam_pkg::qentry_t    wdata,
    input  logic                pop,
    output pam_pkg::qentry_t    rdata,
    output pam_pkg::q_status_t  status
);

    pam_pkg::qentry_t            entry_reg [pam_pkg::QUEUE_DEPTH];
    logic [pam_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [pam_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [pam_pkg::QCNT_W-1:0]  count_reg, count_next;

    function automatic logic [pam_pkg::QPTR_W-1:0] ptr_step(
        input logic [pam_pkg::QPTR_W-1:0] ptr
    );
        return (ptr == pam_pkg::QPTR_W'(pam_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign rdata        = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == pam_pkg::QCNT_W'(pam_pkg::QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);

    assign wr_ptr_next = push ? ptr_step(wr_ptr_reg) : wr_ptr_reg;
    assign rd_ptr_next = pop ? ptr_step(rd_ptr_reg) : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");

endmodule

FILE: rtl/pam_back.sv
`timescale 1ns / 1ps

module pam_back #(
    parameter int AVG_LEN = pam_pkg::AVG_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pam_pkg::q_status_t  q_status,
    input  pam_pkg::qentry_t    q_rdata,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [63:0]         m_axis_tdata
);

    localparam int MULT_W       = pam_pkg::AVG_SHIFT;
    localparam int DIV_PROD_W   = pam_pkg::SUM_W + MULT_W;
    localparam int SPEED_PROD_W = pam_pkg::ADC_W + pam_pkg::SPEED_MUL_W;
    localparam int ANGLE_PROD_W = pam_pkg::ADC_W + pam_pkg::ANGLE_MUL_W;
    localparam int SERVO_PROD_W = 8 + pam_pkg::SERVO_MUL_W;
    localparam logic [MULT_W-1:0] AVG_MULT = MULT_W'(((2 ** MULT_W) + AVG_LEN - 1) / AVG_LEN);

    // stage A: held averages, updated when a block closes
    logic                        a_valid_reg;
    logic [pam_pkg::ADC_W-1:0]   avg_speed_reg, avg_angle_reg;
    logic [pam_pkg::PWM_W-1:0]   a_pwm_reg;
    logic [DIV_PROD_W-1:0]       div_speed_prod, div_angle_prod;
    logic [pam_pkg::ADC_W-1:0]   avg_speed_next, avg_angle_next;

    // stage B: scaled settings
    logic                        b_valid_reg;
    logic [7:0]                  b_scaled_reg, b_abs_angle_reg;
    logic [pam_pkg::PWM_W-1:0]   b_pwm_reg;
    logic [SPEED_PROD_W-1:0]     speed_prod;
    logic [ANGLE_PROD_W-1:0]     angle_prod;

    // stage C: output register
    logic                        c_valid_reg;
    logic [7:0]                  speed_reg, angle_reg, abs_angle_reg;
    logic [6:0]                  abs_speed_reg;
    logic                        in1_reg, in2_reg, enable_reg, led_reg;
    logic [10:0]                 motor_reg;
    logic [11:0]                 servo_reg;
    logic [8:0]                  speed_next, angle_next;
    logic [6:0]                  abs_speed_next;
    logic [SERVO_PROD_W-1:0]     servo_prod;
    logic [11:0]                 servo_next;
    logic [10:0]                 motor_next;
    logic                        speed_nonzero;

    logic                        b_load, c_load;

    assign c_load = b_valid_reg & (~c_valid_reg | m_axis_tready);
    assign b_load = a_valid_reg & (~b_valid_reg | c_load);
    assign q_pop  = q_status.valid & (~a_valid_reg | b_load);

    assign div_speed_prod = DIV_PROD_W'(q_rdata.sum_speed) * DIV_PROD_W'(AVG_MULT);
    assign div_angle_prod = DIV_PROD_W'(q_rdata.sum_angle) * DIV_PROD_W'(AVG_MULT);
    assign avg_speed_next = div_speed_prod[MULT_W+pam_pkg::ADC_W-1:MULT_W];
    assign avg_angle_next = div_angle_prod[MULT_W+pam_pkg::ADC_W-1:MULT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            avg_speed_reg <= '0;
            avg_angle_reg <= '0;
        end
        else if (q_pop)
        begin
            a_valid_reg <= 1'b1;
            if (q_rdata.done)
            begin
                avg_speed_reg <= avg_speed_next;
                avg_angle_reg <= avg_angle_next;
            end
        end
        else if (b_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_pwm_reg <= q_rdata.pwm_cmp;
        end
    end

    assign speed_prod = SPEED_PROD_W'(avg_speed_reg) * SPEED_PROD_W'(pam_pkg::SPEED_MUL);
    assign angle_prod = ANGLE_PROD_W'(avg_angle_reg) * ANGLE_PROD_W'(pam_pkg::ANGLE_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (c_load)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_scaled_reg    <= speed_prod[pam_pkg::SPEED_SHIFT+7:pam_pkg::SPEED_SHIFT];
            b_abs_angle_reg <= angle_prod[pam_pkg::ANGLE_SHIFT+7:pam_pkg::ANGLE_SHIFT];
            b_pwm_reg       <= a_pwm_reg;
        end
    end

    assign speed_next     = {1'b0, b_scaled_reg} - pam_pkg::SPEED_OFFSET;
    assign angle_next     = {1'b0, b_abs_angle_reg} - pam_pkg::ANGLE_OFFSET;
    assign abs_speed_next = speed_next[8] ? 7'(-speed_next) : 7'(speed_next);
    assign speed_nonzero  = (speed_next != '0);
    assign motor_next     = 11'(abs_speed_next) * pam_pkg::MOTOR_GAIN;
    assign servo_prod     = SERVO_PROD_W'(b_abs_angle_reg) * SERVO_PROD_W'(pam_pkg::SERVO_MUL);
    assign servo_next     = pam_pkg::SERVO_BASE
                          + servo_prod[pam_pkg::SERVO_SHIFT+11:pam_pkg::SERVO_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_load)
        begin
            c_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            speed_reg     <= speed_next[7:0];
            angle_reg     <= angle_next[7:0];
            abs_speed_reg <= abs_speed_next;
            abs_angle_reg <= b_abs_angle_reg;
            in1_reg       <= ~speed_next[8] & speed_nonzero;
            in2_reg       <= speed_next[8];
            enable_reg    <= speed_nonzero;
            motor_reg     <= motor_next;
            servo_reg     <= servo_next;
            led_reg       <= (b_pwm_reg > abs_speed_next);
        end
    end

    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tdata  = {6'b0, led_reg, servo_reg, motor_reg, enable_reg, in2_reg, in1_reg,
                            abs_angle_reg, abs_speed_reg, angle_reg, speed_reg};

    a_avg_held: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_rdata.done) |=> $stable(avg_speed_reg) && $stable(avg_angle_reg))
        else $error("held average changed without a closed block");

    a_stage_a_kept: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_load |=> a_valid_reg)
        else $error("stage A item lost");

    a_stage_b_kept: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !c_load |=> b_valid_reg)
        else $error("stage B item lost");

endmodule

FILE: rtl/pot_averaging_motor_servo_pwm.sv
`timescale 1ns / 1ps

// Pot averaging motor and servo PWM controller.
// Input stream: tuser[0] selects the item kind (0 = pot sample pair, 1 = PWM tick);
// tdata carries the speed and angle pot readings. Sample items are averaged in
// blocks of AVG_LEN; the last average is held until the next block closes. A tick
// steps the 0..PWM_STEPS-1 software PWM counter behind led_on.
// Output stream: one transfer per input transfer, in order, carrying the speed and
// angle settings, H-bridge bits, motor and servo compare values and the LED bit.
// Throughput: one item per cycle while m_axis_tready stays high. Each result passes
// the queue, average divide, ratio scaling and output register before it shows on
// m_axis_tvalid (the motor and servo multiplies sit in front of the output register).
// Reset: sums, sample count, held averages and PWM counter all clear; queue and
// pipeline empty.
// Stall: when m_axis_tready is low the pipeline holds its results and the
// four-entry queue keeps taking items; s_axis_tready falls once the queue fills.
module pot_averaging_motor_servo_pwm #(
    parameter int AVG_LEN   = pam_pkg::AVG_LEN_DEF,
    parameter int PWM_STEPS = pam_pkg::PWM_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // adc_chan0[9:0], adc_chan1[19:10], zero pad
    input  logic [0:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // speed_setting[7:0], angle_setting[15:8], abs_speed[22:16], abs_angle[30:23],
    // bridge_in1[31], bridge_in2[32], bridge_enable[33], motor_pulse[44:34],
    // servo_pulse[56:45], led_on[57], zero pad
    output logic [63:0] m_axis_tdata
);

    pam_pkg::q_status_t q_status;
    pam_pkg::qentry_t   q_wdata, q_rdata;
    logic               q_push, q_pop;

    pam_front #(
        .AVG_LEN   (AVG_LEN),
        .PWM_STEPS (PWM_STEPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    pam_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    pam_back #(
        .AVG_LEN (AVG_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
